// ===== design/iplp_pkg.sv =====
package iplp_pkg;

  // Token kinds delivered by the lexer.
  localparam logic [2:0] TK_EOL   = 3'd0;
  localparam logic [2:0] TK_EOF   = 3'd1;
  localparam logic [2:0] TK_DOT   = 3'd2;
  localparam logic [2:0] TK_SLASH = 3'd3;
  localparam logic [2:0] TK_DASH  = 3'd4;
  localparam logic [2:0] TK_INT6  = 3'd5;
  localparam logic [2:0] TK_INT8  = 3'd6;
  localparam logic [2:0] TK_OTHER = 3'd7;

  // Result kinds on the output channel.
  localparam logic [1:0] RK_RANGE = 2'd0;
  localparam logic [1:0] RK_OK    = 2'd1;
  localparam logic [1:0] RK_ERR   = 2'd2;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam logic        REG_LIST_KIND = 1'b0;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Everything one token causes: an optional range and an optional feed status.
  typedef struct packed {
    logic        has_range;
    logic        has_status;
    logic [1:0]  status_kind;
    logic [31:0] first;
    logic [32:0] after;
    logic [7:0]  tag;
  } iplp_entry_t;

  typedef struct packed {
    logic        valid;
    iplp_entry_t entry;
  } iplp_push_t;

endpackage

// ===== design/iplp_tok_if.sv =====
interface iplp_tok_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_value;

  modport source (output valid, output token_kind, output token_value, input ready);
  modport sink (input valid, input token_kind, input token_value, output ready);
endinterface

// ===== design/iplp_res_if.sv =====
interface iplp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] range_first;
  logic [32:0] range_after;
  logic [7:0]  range_tag;
  logic        last_of_run;

  modport source (output valid, output result_kind, output range_first,
                  output range_after, output range_tag, output last_of_run,
                  input ready);
  modport sink (input valid, input result_kind, input range_first,
                input range_after, input range_tag, input last_of_run,
                output ready);
endinterface

// ===== design/ipv4_range_list_parser.sv =====
// IPv4 range list parser: takes one lexer token per word on in_tok and emits
// half-open address ranges, plus one ok or error status at each end of feed,
// on out_res. A token is accepted every cycle while the four-word queue between
// the parser front and the output stage has room; results pass the queue and
// the output register. Each token yields zero, one or two results, and the port
// delivers one result per cycle while out_res.ready is high. A lone address
// closed by end of feed gives a range, then a status. The list_kind register
// (byte address 0) tags every range and should be written only while idle.
module ipv4_range_list_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  iplp_tok_if.sink                        in_tok,
  iplp_res_if.source                      out_res,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [iplp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  logic [7:0]           list_kind_r;
  logic                 cfg_wr;
  logic                 q_full;
  iplp_pkg::iplp_push_t push;

  // Register write and read-back.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == iplp_pkg::REG_LIST_KIND) ? {24'd0, list_kind_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_kind_r <= 8'd0;
    end else if (cfg_wr && cfg_paddr[2] == iplp_pkg::REG_LIST_KIND) begin
      list_kind_r <= cfg_pwdata[7:0];
    end
  end

  iplp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tok    (in_tok),
    .list_kind (list_kind_r),
    .q_full    (q_full),
    .push      (push)
  );

  iplp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_full  (q_full),
    .out_res (out_res)
  );

endmodule

// ===== design/iplp_front.sv =====
module iplp_front (
  input  logic                clk,
  input  logic                rst_n,
  iplp_tok_if.sink            in_tok,
  input  logic [7:0]          list_kind,
  input  logic                q_full,
  output iplp_pkg::iplp_push_t push
);

  // Parser phases.
  localparam logic [3:0] PH_START  = 4'd0;
  localparam logic [3:0] PH_S_DOT  = 4'd1;
  localparam logic [3:0] PH_S_OCT  = 4'd2;
  localparam logic [3:0] PH_AFTER  = 4'd3;
  localparam logic [3:0] PH_PREFIX = 4'd4;
  localparam logic [3:0] PH_E_OCT  = 4'd5;
  localparam logic [3:0] PH_E_DOT  = 4'd6;
  localparam logic [3:0] PH_POST   = 4'd7;
  localparam logic [3:0] PH_DRAIN  = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] first_r, first_nxt;
  logic [31:0] second_r, second_nxt;

  logic        accept;
  logic [2:0]  kind;
  logic [7:0]  val;
  logic        is_octet;
  logic [31:0] first_shift;
  logic [31:0] second_shift;
  logic [31:0] pmask;
  logic [32:0] psize;
  logic [5:0]  pshift;
  logic [31:0] pfirst;

  logic        e_rng;
  logic        e_st;
  logic [1:0]  e_st_kind;
  logic [31:0] e_first;
  logic [32:0] e_after;
  logic        do_fail;
  logic        do_post;

  assign in_tok.ready = !q_full;
  assign accept       = in_tok.valid && in_tok.ready;
  assign kind         = in_tok.token_kind;
  assign val          = in_tok.token_value;
  assign is_octet     = (kind == iplp_pkg::TK_INT6) || (kind == iplp_pkg::TK_INT8);
  assign first_shift  = {first_r[23:0], val};
  assign second_shift = {second_r[23:0], val};

  // Netblock mask and size; only used when the prefix is at most 32.
  assign pshift = 6'd32 - val[5:0];
  assign psize  = 33'd1 << pshift;
  assign pmask  = ~(32'hFFFF_FFFF >> val[5:0]);
  assign pfirst = first_r & pmask;

  // Phase transitions and result formation for one token.
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    e_rng      = 1'b0;
    e_st       = 1'b0;
    e_st_kind  = iplp_pkg::RK_OK;
    e_first    = first_r;
    e_after    = '0;
    do_fail    = 1'b0;
    do_post    = 1'b0;

    unique case (phase_r)
      PH_START, PH_S_OCT: begin
        if (phase_r == PH_START && kind == iplp_pkg::TK_EOL) begin
          phase_nxt = phase_r;
        end else if (!is_octet) begin
          do_fail = 1'b1;
        end else begin
          first_nxt = first_shift;
          if (idx_r == 2'd3) begin
            phase_nxt = PH_AFTER;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            phase_nxt = PH_S_DOT;
          end
        end
      end
      PH_S_DOT: begin
        if (kind == iplp_pkg::TK_DOT) phase_nxt = PH_S_OCT;
        else do_fail = 1'b1;
      end
      PH_AFTER: begin
        if (kind == iplp_pkg::TK_SLASH) begin
          phase_nxt = PH_PREFIX;
        end else if (kind == iplp_pkg::TK_DASH) begin
          idx_nxt   = 2'd0;
          phase_nxt = PH_E_OCT;
        end else begin
          // A lone address ends here; this token then closes the entry.
          e_rng   = 1'b1;
          e_after = {1'b0, first_r} + 33'd1;
          do_post = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (kind == iplp_pkg::TK_INT6 && val <= 8'd32) begin
          e_rng     = 1'b1;
          e_first   = pfirst;
          e_after   = {1'b0, pfirst} + psize;
          phase_nxt = PH_POST;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_E_OCT: begin
        if (!is_octet) begin
          do_fail = 1'b1;
        end else begin
          second_nxt = second_shift;
          if (idx_r == 2'd3) begin
            e_rng     = 1'b1;
            e_after   = {1'b0, second_shift} + 33'd1;
            phase_nxt = PH_POST;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            phase_nxt = PH_E_DOT;
          end
        end
      end
      PH_E_DOT: begin
        if (kind == iplp_pkg::TK_DOT) phase_nxt = PH_E_OCT;
        else do_fail = 1'b1;
      end
      PH_POST: begin
        do_post = 1'b1;
      end
      default: begin
        // Dropping tokens until the end of the feed, then report the error.
        if (kind == iplp_pkg::TK_EOF) begin
          e_st      = 1'b1;
          e_st_kind = iplp_pkg::RK_ERR;
          phase_nxt = PH_START;
          idx_nxt   = 2'd0;
        end
      end
    endcase

    // After a complete entry only end of line continues the feed.
    if (do_post) begin
      if (kind == iplp_pkg::TK_EOL) begin
        phase_nxt = PH_START;
        idx_nxt   = 2'd0;
      end else begin
        do_fail = 1'b1;
      end
    end

    // An unexpected end of feed still counts as success.
    if (do_fail) begin
      if (kind == iplp_pkg::TK_EOF) begin
        e_st      = 1'b1;
        e_st_kind = iplp_pkg::RK_OK;
        phase_nxt = PH_START;
        idx_nxt   = 2'd0;
      end else begin
        phase_nxt = PH_DRAIN;
      end
    end
  end

  // Word handed to the queue.
  always_comb begin
    push.valid             = accept && (e_rng || e_st);
    push.entry.has_range   = e_rng;
    push.entry.has_status  = e_st;
    push.entry.status_kind = e_st_kind;
    push.entry.first       = e_first;
    push.entry.after       = e_after;
    push.entry.tag         = list_kind;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      idx_r    <= 2'd0;
      first_r  <= '0;
      second_r <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  // A word is only pushed for an accepted token, and never into a full queue.
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (accept && !q_full))
    else $error("iplp_front: push without an accepted token");

  // Once dropping, anything but end of feed keeps the parser dropping.
  a_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_DRAIN && kind != iplp_pkg::TK_EOF) |=> phase_r == PH_DRAIN)
    else $error("iplp_front: left the drop phase before end of feed");

  // No range comes out while tokens are being dropped.
  a_drain_no_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DRAIN) |-> !e_rng)
    else $error("iplp_front: range emitted while dropping");

endmodule

// ===== design/iplp_back.sv =====
module iplp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iplp_pkg::iplp_push_t push,
  output logic                 q_full,
  iplp_res_if.source           out_res
);

  iplp_pkg::iplp_entry_t mem_r [iplp_pkg::QDEPTH];

  logic [iplp_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [iplp_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [iplp_pkg::QCNT_W-1:0] count_r, count_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [31:0] out_first_r, out_first_nxt;
  logic [32:0] out_after_r, out_after_nxt;
  logic [7:0]  out_tag_r, out_tag_nxt;
  logic        out_last_r, out_last_nxt;
  logic        pend_r, pend_nxt;
  logic [1:0]  pend_kind_r, pend_kind_nxt;

  iplp_pkg::iplp_entry_t head;
  logic                  load;
  logic                  pop;
  logic                  q_empty;

  assign q_full  = (count_r == iplp_pkg::QCNT_W'(iplp_pkg::QDEPTH));
  assign q_empty = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign load    = !out_valid_r || out_res.ready;
  assign pop     = load && !pend_r && !q_empty;

  // Output stage: a status that follows a range waits one word in pend_r.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_first_nxt = out_first_r;
    out_after_nxt = out_after_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;
    pend_nxt      = pend_r;
    pend_kind_nxt = pend_kind_r;

    if (load) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = pend_kind_r;
        out_first_nxt = '0;
        out_after_nxt = '0;
        out_tag_nxt   = '0;
        out_last_nxt  = 1'b1;
        pend_nxt      = 1'b0;
      end else if (!q_empty) begin
        out_valid_nxt = 1'b1;
        if (head.has_range) begin
          out_kind_nxt  = iplp_pkg::RK_RANGE;
          out_first_nxt = head.first;
          out_after_nxt = head.after;
          out_tag_nxt   = head.tag;
          out_last_nxt  = !head.has_status;
          pend_nxt      = head.has_status;
          pend_kind_nxt = head.status_kind;
        end else begin
          out_kind_nxt  = head.status_kind;
          out_first_nxt = '0;
          out_after_nxt = '0;
          out_tag_nxt   = '0;
          out_last_nxt  = 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) count_nxt = count_r + 1'b1;
    else if (!push.valid && pop) count_nxt = count_r - 1'b1;
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  // Queue pointers and output control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Output word registers.
  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_first_r <= out_first_nxt;
    out_after_r <= out_after_nxt;
    out_tag_r   <= out_tag_nxt;
    out_last_r  <= out_last_nxt;
    pend_kind_r <= pend_kind_nxt;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.result_kind = out_kind_r;
  assign out_res.range_first = out_first_r;
  assign out_res.range_after = out_after_r;
  assign out_res.range_tag   = out_tag_r;
  assign out_res.last_of_run = out_last_r;

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= iplp_pkg::QCNT_W'(iplp_pkg::QDEPTH))
    else $error("iplp_back: queue overflow");

  // A waiting status always sits behind a range word still on the port.
  a_pend_behind_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (out_valid_r && !out_last_r && out_kind_r == iplp_pkg::RK_RANGE))
    else $error("iplp_back: pending status without its range");

  // Nothing is pushed into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push.valid)
    else $error("iplp_back: push into full queue");

endmodule
